// ===== sv/sfq_pkg.sv =====
// Package for the searchable FIFO table: command and status codes, controller states,
// per-cell control bundle and default sizes. No dependencies.
package sfq_pkg;

  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefValueBits = 32;

  localparam int unsigned KeyBits   = 32;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned PosBits   = 5;
  localparam int unsigned ModeBits  = 3;
  localparam int unsigned StatBits  = 2;

  typedef enum logic [ModeBits-1:0] {
    MODE_ENQ       = 3'd0,
    MODE_DEQ       = 3'd1,
    MODE_FIND_KEY  = 3'd2,
    MODE_FIND_VAL  = 3'd3,
    MODE_READ      = 3'd4,
    MODE_SET_KEY   = 3'd5,
    MODE_SET_VAL   = 3'd6,
    MODE_SET_BOTH  = 3'd7
  } mode_t;

  typedef enum logic [StatBits-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic shift;
    logic wr_key;
    logic wr_val;
    logic cmp_load;
    logic cmp_by_key;
  } cell_ctrl_t;

endpackage

// ===== sv/sfq_cell.sv =====
// One storage cell of the table: holds the key and value of one queue position.
// Depends on sfq_pkg for the control bundle and key width.
module sfq_cell #(
  parameter int unsigned STORE_BITS = 32
) (
  input  logic                              clk,
  input  sfq_pkg::cell_ctrl_t               ctrl,
  input  logic signed [sfq_pkg::KeyBits-1:0] nbr_key,
  input  logic [STORE_BITS-1:0]             nbr_val,
  input  logic signed [sfq_pkg::KeyBits-1:0] wr_key,
  input  logic [STORE_BITS-1:0]             wr_val,
  input  logic signed [sfq_pkg::KeyBits-1:0] cmp_key,
  input  logic [STORE_BITS-1:0]             cmp_val,
  output logic signed [sfq_pkg::KeyBits-1:0] key_r,
  output logic [STORE_BITS-1:0]             val_r,
  output logic                              match_r
);

  logic match_nxt;

  assign match_nxt = ctrl.cmp_by_key ? (key_r == cmp_key) : (val_r == cmp_val);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key_r <= nbr_key;
      val_r <= nbr_val;
    end else begin
      if (ctrl.wr_key) begin
        key_r <= wr_key;
      end
      if (ctrl.wr_val) begin
        val_r <= wr_val;
      end
    end
    if (ctrl.cmp_load) begin
      match_r <= match_nxt;
    end
  end

endmodule

// ===== sv/sfq_pick.sv =====
// Priority picker: finds the live cell nearest the head whose stored match bit is set.
// Depends on nothing but its parameter.
module sfq_pick #(
  parameter int unsigned DEPTH = 16
) (
  input  logic [DEPTH-1:0]         hits,
  output logic                     any_hit,
  output logic [$clog2(DEPTH)-1:0] hit_pos
);

  always_comb begin
    any_hit = 1'b0;
    hit_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        any_hit = 1'b1;
        hit_pos = ($clog2(DEPTH))'(i);
      end
    end
  end

endmodule

// ===== sv/searchable_fifo_table.sv =====
// Searchable FIFO table: a bounded queue of key and value entries with associative search.
// Usage: one command is transferred on the in_ channel (in_valid, in_stall) and exactly
// one result is transferred on the out_ channel (out_valid, out_stall) for each command.
// Entries sit in a row of cells, cell 0 holding position 1 at the head; a dequeue shifts
// every cell one place towards the head. The transfer edge registers the command and the
// key or value compare in every cell; in the execute state the table picks the hit,
// updates the cells and loads the output register. A new command is accepted only once
// the previous one has executed.
// A new command may be transferred while an earlier result still waits on out_stall;
// its execution then holds until that result has been transferred, and in_stall stays
// high meanwhile.
// Reset (rst_n low, synchronous) empties the queue and drops any pending command or
// result. Cell contents are not cleared; only occupied positions are ever read.
// Depends on sfq_pkg, sfq_cell and sfq_pick.
module searchable_fifo_table #(
  parameter int unsigned DEPTH      = sfq_pkg::DefDepth,
  parameter int unsigned VALUE_BITS = sfq_pkg::DefValueBits
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sfq_pkg::ModeBits-1:0]        in_mode,
  input  logic signed [sfq_pkg::KeyBits-1:0]  in_key,
  input  logic [sfq_pkg::WordBits-1:0]        in_value,
  input  logic [sfq_pkg::PosBits-1:0]         in_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sfq_pkg::StatBits-1:0]        out_status,
  output logic [sfq_pkg::PosBits-1:0]         out_found_index,
  output logic signed [sfq_pkg::KeyBits-1:0]  out_entry_key,
  output logic [sfq_pkg::WordBits-1:0]        out_entry_value,
  output logic [sfq_pkg::PosBits-1:0]         out_occupancy
);

  localparam int unsigned SW = (VALUE_BITS < sfq_pkg::WordBits) ? VALUE_BITS
                                                                 : sfq_pkg::WordBits;
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > sfq_pkg::PosBits) ? CW : sfq_pkg::PosBits;

  sfq_pkg::state_t                     state_r, state_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  sfq_pkg::mode_t                      mode_r;
  logic signed [sfq_pkg::KeyBits-1:0]  cmd_key_r;
  logic [SW-1:0]                       cmd_val_r;
  logic [sfq_pkg::PosBits-1:0]         cmd_idx_r;

  logic                                out_valid_r, out_valid_nxt;
  sfq_pkg::status_t                    out_status_r, out_status_nxt;
  logic [sfq_pkg::PosBits-1:0]         out_pos_r, out_pos_nxt;
  logic signed [sfq_pkg::KeyBits-1:0]  out_key_r, out_key_nxt;
  logic [SW-1:0]                       out_val_r, out_val_nxt;
  logic [sfq_pkg::PosBits-1:0]         out_occ_r;

  sfq_pkg::cell_ctrl_t                 ctrl [DEPTH];
  logic signed [sfq_pkg::KeyBits-1:0]  cell_key [DEPTH];
  logic [SW-1:0]                       cell_val [DEPTH];
  logic [DEPTH-1:0]                    cell_match;
  logic [DEPTH-1:0]                    live_hits;

  logic                                in_xfer;
  logic                                out_xfer;
  logic                                exec_go;
  logic                                any_hit;
  logic [PW-1:0]                       hit_pos;
  logic [PW-1:0]                       rd_sel;
  logic [PW-1:0]                       wr_sel;
  logic [IW-1:0]                       idx_ext;
  logic                                idx_ok;
  logic                                do_shift;
  logic                                do_wr_key;
  logic                                do_wr_val;
  logic [PW-1:0]                       enq_sel;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != sfq_pkg::ST_IDLE);
  assign exec_go  = (state_r == sfq_pkg::ST_EXEC) && !(out_valid_r && out_stall);

  assign idx_ext = IW'(cmd_idx_r);
  assign idx_ok  = (cmd_idx_r != '0) && (idx_ext <= IW'(count_r));
  assign enq_sel = PW'(count_r);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live_hits[i] = cell_match[i] && (CW'(i) < count_r);
    end
  end

  sfq_pick #(
    .DEPTH (DEPTH)
  ) u_pick (
    .hits    (live_hits),
    .any_hit (any_hit),
    .hit_pos (hit_pos)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [sfq_pkg::KeyBits-1:0] nbr_key;
    logic [SW-1:0]                      nbr_val;

    if (g == DEPTH - 1) begin : g_last
      assign nbr_key = cell_key[g];
      assign nbr_val = cell_val[g];
    end else begin : g_mid
      assign nbr_key = cell_key[g+1];
      assign nbr_val = cell_val[g+1];
    end

    always_comb begin
      ctrl[g].shift      = do_shift;
      ctrl[g].wr_key     = do_wr_key && (wr_sel == PW'(g));
      ctrl[g].wr_val     = do_wr_val && (wr_sel == PW'(g));
      ctrl[g].cmp_load   = in_xfer;
      ctrl[g].cmp_by_key = (in_mode == sfq_pkg::MODE_FIND_KEY);
    end

    sfq_cell #(
      .STORE_BITS (SW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl[g]),
      .nbr_key (nbr_key),
      .nbr_val (nbr_val),
      .wr_key  (cmd_key_r),
      .wr_val  (cmd_val_r),
      .cmp_key (in_key),
      .cmp_val (in_value[SW-1:0]),
      .key_r   (cell_key[g]),
      .val_r   (cell_val[g]),
      .match_r (cell_match[g])
    );
  end

  always_comb begin
    rd_sel = PW'(idx_ext - IW'(1));
    unique case (mode_r) inside
      sfq_pkg::MODE_DEQ:                              rd_sel = '0;
      sfq_pkg::MODE_FIND_KEY, sfq_pkg::MODE_FIND_VAL: rd_sel = hit_pos;
      default:                                        rd_sel = PW'(idx_ext - IW'(1));
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfq_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r    <= sfq_pkg::mode_t'(in_mode);
      cmd_key_r <= in_key;
      cmd_val_r <= in_value[SW-1:0];
      cmd_idx_r <= in_index;
    end
    if (exec_go) begin
      out_status_r <= out_status_nxt;
      out_pos_r    <= out_pos_nxt;
      out_key_r    <= out_key_nxt;
      out_val_r    <= out_val_nxt;
      out_occ_r    <= sfq_pkg::PosBits'(IW'(count_nxt));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_xfer;
    out_status_nxt = sfq_pkg::STAT_MISS;
    out_pos_nxt    = '0;
    out_key_nxt    = '0;
    out_val_nxt    = '0;
    do_shift       = 1'b0;
    do_wr_key      = 1'b0;
    do_wr_val      = 1'b0;
    wr_sel         = rd_sel;

    unique case (state_r)
      sfq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = sfq_pkg::ST_EXEC;
        end
      end
      sfq_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_nxt     = sfq_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          unique case (mode_r) inside
            sfq_pkg::MODE_ENQ: begin
              if (count_r == CW'(DEPTH)) begin
                out_status_nxt = sfq_pkg::STAT_FULL;
              end else begin
                wr_sel         = enq_sel;
                do_wr_key      = 1'b1;
                do_wr_val      = 1'b1;
                count_nxt      = count_r + CW'(1);
                out_status_nxt = sfq_pkg::STAT_OK;
                out_pos_nxt    = sfq_pkg::PosBits'(IW'(count_r) + IW'(1));
                out_key_nxt    = cmd_key_r;
                out_val_nxt    = cmd_val_r;
              end
            end
            sfq_pkg::MODE_DEQ: begin
              if (count_r != '0) begin
                do_shift       = 1'b1;
                count_nxt      = count_r - CW'(1);
                out_status_nxt = sfq_pkg::STAT_OK;
                out_pos_nxt    = sfq_pkg::PosBits'(1);
                out_key_nxt    = cell_key[rd_sel];
                out_val_nxt    = cell_val[rd_sel];
              end
            end
            sfq_pkg::MODE_FIND_KEY, sfq_pkg::MODE_FIND_VAL: begin
              if (any_hit) begin
                out_status_nxt = sfq_pkg::STAT_OK;
                out_pos_nxt    = sfq_pkg::PosBits'(IW'(hit_pos) + IW'(1));
                out_key_nxt    = cell_key[rd_sel];
                out_val_nxt    = cell_val[rd_sel];
              end
            end
            default: begin
              if (idx_ok) begin
                do_wr_key      = (mode_r == sfq_pkg::MODE_SET_KEY) ||
                                 (mode_r == sfq_pkg::MODE_SET_BOTH);
                do_wr_val      = (mode_r == sfq_pkg::MODE_SET_VAL) ||
                                 (mode_r == sfq_pkg::MODE_SET_BOTH);
                out_status_nxt = sfq_pkg::STAT_OK;
                out_pos_nxt    = cmd_idx_r;
                out_key_nxt    = do_wr_key ? cmd_key_r : cell_key[rd_sel];
                out_val_nxt    = do_wr_val ? cmd_val_r : cell_val[rd_sel];
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = sfq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_pos_r;
  assign out_entry_key   = out_key_r;
  assign out_entry_value = sfq_pkg::WordBits'(out_val_r);
  assign out_occupancy   = out_occ_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Occupancy exceeds the table depth.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(exec_go) |-> count_r == $past(count_r))
    else $error("Occupancy changed without a command being executed.");

  a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != sfq_pkg::STAT_OK) |->
      (out_pos_r == '0 && out_key_r == '0 && out_val_r == '0))
    else $error("A failed command reported entry data.");

  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == sfq_pkg::ST_EXEC)
    else $error("An accepted command was not taken into execution.");
`endif

endmodule
